@@ hdl/msbs_pkg.sv @@
// Shared types and constants for the multi-signature byte scanner.
// No dependencies; used by every scanner module but the checker.
`default_nettype none
package msbs_pkg;

    // Fixed field and register widths
    localparam int BYTE_W     = 8;
    localparam int SIG_W      = 64;
    localparam int OFFSET_W   = 32;
    localparam int MASK_W     = 7;
    localparam int SIG_SLOTS  = 7;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int REG_IDX_W  = 3;

    // Output beat: mask in the low bits, offset above, one pad bit
    localparam int OUT_TDATA_W = 40;

    // Register map (index = paddr / 8)
    localparam logic [REG_IDX_W-1:0] REG_BASE_OFFSET = 3'd7;

    localparam logic [OFFSET_W-1:0] BASE_OFFSET_RESET = 32'd100000;

    typedef logic [SIG_W-1:0] sig_t;
    typedef logic [SIG_SLOTS-1:0][SIG_W-1:0] sig_array_t;

    // Per-beat control broadcast to every signature lane
    typedef struct packed {
        logic             advance;
        logic             start;
        logic [BYTE_W-1:0] data_byte;
    } match_step_t;

endpackage
`default_nettype wire

@@ hdl/msbs_cfg_regs.sv @@
// Configuration register file of the scanner: seven signatures and the base offset.
// Depends on msbs_pkg; APB-style write and read access.
`default_nettype none
module msbs_cfg_regs (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [msbs_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [msbs_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [msbs_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output msbs_pkg::sig_array_t                  signatures,
    output logic      [msbs_pkg::OFFSET_W-1:0]    base_offset
);

    msbs_pkg::sig_array_t                sig_reg;
    logic [msbs_pkg::OFFSET_W-1:0]       base_reg;
    logic [msbs_pkg::REG_IDX_W-1:0]      reg_idx;
    logic                                wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[msbs_pkg::CFG_ADDR_W-1:msbs_pkg::CFG_ADDR_W-msbs_pkg::REG_IDX_W];
    assign wr_en   = psel & penable & pwrite & pready;

    // Write in the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sig_reg  <= '0;
            base_reg <= msbs_pkg::BASE_OFFSET_RESET;
        end else if (wr_en) begin
            if (reg_idx == msbs_pkg::REG_BASE_OFFSET) begin
                base_reg <= pwdata[msbs_pkg::OFFSET_W-1:0];
            end else begin
                sig_reg[reg_idx] <= pwdata[msbs_pkg::SIG_W-1:0];
            end
        end
    end

    // Read back the addressed register
    always_comb begin
        if (reg_idx == msbs_pkg::REG_BASE_OFFSET) begin
            prdata = msbs_pkg::CFG_DATA_W'(base_reg);
        end else begin
            prdata = msbs_pkg::CFG_DATA_W'(sig_reg[reg_idx]);
        end
    end

    assign signatures  = sig_reg;
    assign base_offset = base_reg;

endmodule
`default_nettype wire

@@ hdl/msbs_matcher.sv @@
// One signature lane: progress counter and byte compare for a single signature.
// Depends on msbs_pkg; instantiated once per active signature by the top level.
`default_nettype none
module msbs_matcher #(
    parameter int SIGNATURE_BYTES = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire msbs_pkg::match_step_t step,
    input  wire msbs_pkg::sig_t        signature,
    output logic                       completed
);

    localparam int PW = $clog2(SIGNATURE_BYTES + 1);
    localparam logic [PW-1:0] FULL = PW'(SIGNATURE_BYTES);

    logic [PW-1:0]               progress_reg;
    logic [PW-1:0]               progress_next;
    logic [PW-1:0]               progress_cur;
    logic [msbs_pkg::BYTE_W-1:0] expect_byte;

    // Restart the count on the first byte of a scan
    assign progress_cur = step.start ? '0 : progress_reg;

    // Pick the next expected signature byte
    always_comb begin
        expect_byte = '0;
        for (int k = 0; k < SIGNATURE_BYTES; k++) begin
            if (progress_cur == PW'(k)) begin
                expect_byte = signature[k*msbs_pkg::BYTE_W +: msbs_pkg::BYTE_W];
            end
        end
    end

    // Advance on a hit, drop to zero on a miss, hold once finished
    always_comb begin
        progress_next = progress_cur;
        completed     = 1'b0;
        if (progress_cur < FULL) begin
            if (expect_byte == step.data_byte) begin
                progress_next = progress_cur + PW'(1);
                completed     = (progress_cur == FULL - PW'(1));
            end else begin
                progress_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            progress_reg <= '0;
        end else if (step.advance) begin
            progress_reg <= progress_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/multi_signature_byte_scanner_top.sv @@
// Usage notes for the multi-signature byte scanner.
// Input beats (s_ channel) carry one stream byte in s_tdata and a start-of-scan
// flag in s_tuser. Each beat yields exactly one output beat (m_ channel) with a
// mask of signatures that completed on that byte and the offset of their first
// byte (zero when the mask is zero).
// Pipeline: an input beat is taken into the input register; the byte is
// compared out of the input register and the result lands in the output
// register when the output register is free or draining. Throughput: one
// byte per cycle while the receiver does not stall, set by the update of the
// per-signature progress counters and the offset counter.
// Signatures and the base offset are written over the APB-style port at byte
// address 8*i; write them only while no beat is in flight. Start of scan
// clears all progress counters and loads the offset with the base offset.
// Reset (aresetn low, synchronous) clears the pipeline, the counters and the
// registers (signatures 0, base offset 100000).
// When the receiver stalls, the output beat holds and the input register fills;
// s_tready then drops until m_tready returns.
// Depends on msbs_pkg, msbs_cfg_regs and msbs_matcher.
`default_nettype none
module multi_signature_byte_scanner_top #(
    parameter int NUM_SIGNATURES  = 7,
    parameter int SIGNATURE_BYTES = 8
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [msbs_pkg::BYTE_W-1:0]         s_tdata,   // [7:0] data_byte
    input  wire logic                                s_tuser,   // [0] start_of_scan
    // Result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [6:0] match_mask, [38:7] match_offset, [39] zero
    output logic      [msbs_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // Configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [msbs_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [msbs_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic      [msbs_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                     pready
);

    msbs_pkg::sig_array_t              signatures;
    logic [msbs_pkg::OFFSET_W-1:0]     base_offset;

    logic                              in_valid_reg;
    logic [msbs_pkg::BYTE_W-1:0]       in_byte_reg;
    logic                              in_start_reg;
    logic                              advance;

    logic [msbs_pkg::OFFSET_W-1:0]     offset_reg;
    logic [msbs_pkg::OFFSET_W-1:0]     offset_cur;

    logic [NUM_SIGNATURES-1:0]         hit;
    logic [msbs_pkg::MASK_W-1:0]       mask_next;
    logic [msbs_pkg::OFFSET_W-1:0]     moff_next;

    logic                              out_valid_reg;
    logic [msbs_pkg::MASK_W-1:0]       mask_reg;
    logic [msbs_pkg::OFFSET_W-1:0]     moff_reg;

    msbs_pkg::match_step_t             step;

    msbs_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .signatures  (signatures),
        .base_offset (base_offset)
    );

    // Process the held byte whenever the output register is free or draining
    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready & s_tvalid) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    assign step.advance   = advance;
    assign step.start     = in_start_reg;
    assign step.data_byte = in_byte_reg;

    // One compare lane per active signature
    for (genvar n = 0; n < NUM_SIGNATURES; n++) begin : g_lane
        msbs_matcher #(
            .SIGNATURE_BYTES (SIGNATURE_BYTES)
        ) u_matcher (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .step      (step),
            .signature (signatures[n]),
            .completed (hit[n])
        );
    end

    // Stream offset of the current byte
    assign offset_cur = in_start_reg ? base_offset : offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= msbs_pkg::BASE_OFFSET_RESET;
        end else if (advance) begin
            offset_reg <= offset_cur + msbs_pkg::OFFSET_W'(1);
        end
    end

    // Form the result; offset reads zero when nothing completed
    always_comb begin
        mask_next = msbs_pkg::MASK_W'(hit);
        if (mask_next != '0) begin
            moff_next = offset_cur - msbs_pkg::OFFSET_W'(SIGNATURE_BYTES - 1);
        end else begin
            moff_next = '0;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            mask_reg <= mask_next;
            moff_reg <= moff_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, moff_reg, mask_reg};

endmodule
`default_nettype wire

@@ hdl/msbs_checker.sv @@
// Port-level checks on the scanner's result channel, bound to the top level.
// Depends on multi_signature_byte_scanner_top port names and its NUM_SIGNATURES parameter only.
`default_nettype none
module msbs_checker #(
    parameter int NUM_SIGNATURES = 7
) (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);

    // No result beat right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat valid after reset");

    // Stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // Offset is zero when no signature completed
    a_zero_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[6:0] == 7'd0) |-> (m_tdata[38:7] == 32'd0))
        else $error("offset set without a match");

    // Unused lanes and pad bit never report
    a_unused: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[6:0] >> NUM_SIGNATURES) == 7'd0) && !m_tdata[39])
        else $error("match on an unused signature lane");

endmodule

bind multi_signature_byte_scanner_top msbs_checker #(
    .NUM_SIGNATURES (NUM_SIGNATURES)
) u_msbs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

@@ tb/tb_multi_signature_byte_scanner_top.sv @@
// Self-checking testbench for multi_signature_byte_scanner_top: drives byte beats and APB
// writes, checks each result beat in order against a local scanner model or a typed value.
// Depends on msbs_pkg and the scanner RTL.
module tb_multi_signature_byte_scanner_top;

    localparam int NUM_SIGNATURES  = 7;
    localparam int SIGNATURE_BYTES = 8;
    localparam int RANDOM_PHASES   = 12;
    localparam int PHASE_BEATS     = 150;
    localparam int HOLD_PHASE      = 3;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int MAX_REPORTS     = 10;

    localparam logic [msbs_pkg::REG_IDX_W-1:0] REG_SIGNATURE_0 = 3'd0;

    typedef struct packed {
        logic [msbs_pkg::MASK_W-1:0]   mask;
        logic [msbs_pkg::OFFSET_W-1:0] offset;
    } scan_result_t;

    typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t                         kind;
        logic [7:0]                        data;
        logic                              sos;
        logic                              typed;
        scan_result_t                      want;
        logic [msbs_pkg::REG_IDX_W-1:0]    reg_idx;
        logic [msbs_pkg::CFG_DATA_W-1:0]   reg_val;
    } stim_row_t;

    // Clock, reset and block ports
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [msbs_pkg::BYTE_W-1:0]        s_tdata  = '0;    // [7:0] data_byte
    logic                               s_tuser  = 1'b0;  // [0] start_of_scan
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [msbs_pkg::OUT_TDATA_W-1:0]   m_tdata;          // [6:0] mask, [38:7] offset
    logic                               psel     = 1'b0;
    logic                               penable  = 1'b0;
    logic                               pwrite   = 1'b0;
    logic [msbs_pkg::CFG_ADDR_W-1:0]    paddr    = '0;
    logic [msbs_pkg::CFG_DATA_W-1:0]    pwdata   = '0;
    logic [msbs_pkg::CFG_DATA_W-1:0]    prdata;
    logic                               pready;

    // Sideband that travels with each offered beat: typed-in expectation, if any
    logic         beat_typed = 1'b0;
    scan_result_t beat_want  = '0;

    // Scanner model state
    logic [msbs_pkg::SIG_W-1:0]    sig_model [msbs_pkg::SIG_SLOTS];
    logic [3:0]                    progress_model [msbs_pkg::SIG_SLOTS];
    logic [msbs_pkg::OFFSET_W-1:0] base_model;
    logic [msbs_pkg::OFFSET_W-1:0] offset_model;

    scan_result_t expected_matches [$];
    stim_row_t    directed_rows [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    bit source_idle    = 1'b1;
    bit sink_idle      = 1'b1;
    bit hold_off_req   = 1'b0;

    always #2 aclk = ~aclk;

    multi_signature_byte_scanner_top #(
        .NUM_SIGNATURES  (NUM_SIGNATURES),
        .SIGNATURE_BYTES (SIGNATURE_BYTES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Advance every signature's progress by one byte and build the match beat
    function automatic scan_result_t scan_byte(input logic [7:0] data, input logic sos);
        scan_result_t res;
        logic [3:0]   step;
        int           n;
        res = '0;
        if (sos) begin
            for (n = 0; n < msbs_pkg::SIG_SLOTS; n++) progress_model[n] = '0;
            offset_model = base_model;
        end
        for (n = 0; n < NUM_SIGNATURES; n++) begin
            step = progress_model[n];
            if (step < SIGNATURE_BYTES) begin
                // A mismatch drops to zero without retrying this byte as a first byte
                if (sig_model[n][8*step +: 8] == data) begin
                    step = step + 4'd1;
                    if (step == SIGNATURE_BYTES) res.mask[n] = 1'b1;
                end else begin
                    step = '0;
                end
                progress_model[n] = step;
            end
        end
        if (res.mask != '0) res.offset = offset_model - (SIGNATURE_BYTES - 1);
        offset_model = offset_model + 1;
        return res;
    endfunction

    function automatic void flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function automatic stim_row_t beat_row(input logic [7:0] data, input logic sos);
        stim_row_t row;
        row = '{ROW_BEAT, data, sos, 1'b0, '0, '0, '0};
        return row;
    endfunction

    function automatic stim_row_t typed_row(input logic [7:0] data, input logic sos,
                                            input logic [6:0] mask, input logic [31:0] offset);
        stim_row_t row;
        row = '{ROW_BEAT, data, sos, 1'b1, '{mask, offset}, '0, '0};
        return row;
    endfunction

    function automatic stim_row_t cfg_row(input logic [2:0] idx, input logic [63:0] value);
        stim_row_t row;
        row = '{ROW_CFG, '0, 1'b0, 1'b0, '0, idx, value};
        return row;
    endfunction

    function automatic logic [7:0] pick_alphabet_byte();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h5A;
            default: return 8'hA5;
        endcase
    endfunction

    // Mostly small-alphabet signatures so partial matches and overlaps are common
    function automatic logic [63:0] pick_signature();
        logic [63:0] sig;
        logic [7:0]  fill;
        int          k;
        fill = pick_alphabet_byte();
        case ($urandom_range(0, 7))
            0:       sig = '0;
            1:       sig = '1;
            2:       sig = {$urandom, $urandom};
            default: begin
                for (k = 0; k < 8; k++)
                    sig[8*k +: 8] = ($urandom_range(0, 2) == 0) ? fill : pick_alphabet_byte();
            end
        endcase
        return sig;
    endfunction

    // Offer one byte beat, after a random gap if source_idle is set; return at the edge that takes it
    task automatic offer_byte(input logic [7:0] data, input logic sos,
                              input logic typed, input scan_result_t want);
        int gap;
        gap = source_idle ? $urandom_range(0, 6) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= data;
        s_tuser    <= sos;
        beat_typed <= typed;
        beat_want  <= want;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stop offering and wait until every expected beat is out and the pipe is empty
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_matches.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // APB write: setup phase, access phase, then an idle phase
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == msbs_pkg::REG_BASE_OFFSET) base_model = value[31:0];
        else sig_model[idx] = value;
        @(posedge aclk);
    endtask

    // Predict on accepted input beats, check accepted result beats
    always @(posedge aclk) begin
        scan_result_t predicted;
        scan_result_t want;
        scan_result_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predicted = scan_byte(s_tdata, s_tuser);
                expected_matches.push_back(beat_typed ? beat_want : predicted);
            end
            if (m_tvalid && m_tready) begin
                got.mask   = m_tdata[6:0];
                got.offset = m_tdata[38:7];
                if (expected_matches.size() == 0) begin
                    flag_mismatch($sformatf(
                        "cycle %0d: unexpected result beat mask %02h offset %08h",
                        cycle_count, got.mask, got.offset));
                end else begin
                    want = expected_matches.pop_front();
                    if (got.mask !== want.mask || got.offset !== want.offset
                            || m_tdata[39] !== 1'b0) begin
                        flag_mismatch($sformatf(
                            {"cycle %0d: expected mask %02h offset %08h, ",
                             "got mask %02h offset %08h pad %b"},
                            cycle_count, want.mask, want.offset, got.mask, got.offset,
                            m_tdata[39]));
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result sink: random stalls per beat when sink_idle is set, one long hold-off on request
    initial begin : result_sink
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            stall = sink_idle ? $urandom_range(0, 6) : 0;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Main sequence
    initial begin : stimulus
        int          phase;
        int          sent;
        int          n;
        int          k;
        int          len;
        int          bad_at;
        int          choice;
        logic [7:0]  data;
        logic        sos;
        logic [31:0] base;
        bit          hold_done;
        stim_row_t   row;

        for (n = 0; n < msbs_pkg::SIG_SLOTS; n++) begin
            sig_model[n]      = '0;
            progress_model[n] = '0;
        end
        base_model   = msbs_pkg::BASE_OFFSET_RESET;
        offset_model = msbs_pkg::BASE_OFFSET_RESET;
        hold_done    = 1'b0;

        // Reset values: zero signatures all finish on the eighth zero byte, then hold
        for (n = 0; n < 7; n++) directed_rows.push_back(typed_row(8'h00, 1'b0, 7'h00, 32'h0));
        directed_rows.push_back(typed_row(8'h00, 1'b0, 7'h7F, 32'd100000));
        directed_rows.push_back(typed_row(8'h00, 1'b0, 7'h00, 32'h0));
        // All-ones signature across the offset wrap
        directed_rows.push_back(cfg_row(REG_SIGNATURE_0, 64'hFFFF_FFFF_FFFF_FFFF));
        directed_rows.push_back(cfg_row(REG_SIGNATURE_0 + 3'd1, 64'h4847_4645_4443_4141));
        directed_rows.push_back(cfg_row(msbs_pkg::REG_BASE_OFFSET, 64'h0000_0000_FFFF_FFFB));
        directed_rows.push_back(beat_row(8'hFF, 1'b1));
        for (n = 0; n < 6; n++) directed_rows.push_back(beat_row(8'hFF, 1'b0));
        directed_rows.push_back(typed_row(8'hFF, 1'b0, 7'h01, 32'hFFFF_FFFB));
        // Repeated first byte: the third 0x41 drops progress and is not retried
        directed_rows.push_back(beat_row(8'h41, 1'b0));
        directed_rows.push_back(beat_row(8'h41, 1'b0));
        directed_rows.push_back(beat_row(8'h41, 1'b0));
        for (n = 0; n < 5; n++) directed_rows.push_back(beat_row(8'h43 + 8'(n), 1'b0));
        directed_rows.push_back(typed_row(8'h48, 1'b0, 7'h00, 32'h0));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG) begin
                wait_idle();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                offer_byte(row.data, row.sos, row.typed, row.want);
            end
        end

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            // Reconfigure between phases; no start flag, so this also lands mid-scan
            wait_idle();
            for (n = 0; n < msbs_pkg::SIG_SLOTS; n++)
                if (phase == 0 || $urandom_range(0, 2) == 0)
                    write_reg(REG_SIGNATURE_0 + 3'(n), pick_signature());
            if (phase < 2 || $urandom_range(0, 1) == 0) begin
                case (phase)
                    0:       base = '0;
                    1:       base = '1;
                    default: base = ($urandom_range(0, 1) == 0) ? $urandom : 32'hFFFF_FFF9;
                endcase
                write_reg(msbs_pkg::REG_BASE_OFFSET, {$urandom, base});
            end
            source_idle = (phase != HOLD_PHASE) && ($urandom_range(0, 2) != 0);
            sink_idle   = ($urandom_range(0, 2) != 0);

            sent = 0;
            while (sent < PHASE_BEATS) begin
                choice = $urandom_range(0, 19);
                if (choice < 11) begin
                    // Whole signature, sometimes cut short or with one byte spoiled
                    n      = $urandom_range(0, NUM_SIGNATURES - 1);
                    len    = SIGNATURE_BYTES;
                    bad_at = -1;
                    if ($urandom_range(0, 3) == 0) begin
                        if ($urandom_range(0, 1) == 0) len = $urandom_range(1, SIGNATURE_BYTES - 1);
                        else bad_at = $urandom_range(0, SIGNATURE_BYTES - 1);
                    end
                    sos = ($urandom_range(0, 4) == 0);
                    for (k = 0; k < len; k++) begin
                        data = (k == bad_at) ? 8'($urandom) : sig_model[n][8*k +: 8];
                        offer_byte(data, sos && (k == 0), 1'b0, '0);
                        sent++;
                    end
                end else begin
                    data = (choice < 16) ? pick_alphabet_byte() : 8'($urandom);
                    offer_byte(data, $urandom_range(0, 29) == 0, 1'b0, '0);
                    sent++;
                end
                // Stall the sink for a long stretch while beats keep coming
                if (phase == HOLD_PHASE && sent >= 20 && !hold_done) begin
                    hold_off_req = 1'b1;
                    hold_done    = 1'b1;
                end
            end
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/msbs_pkg.sv
hdl/msbs_cfg_regs.sv
hdl/msbs_matcher.sv
hdl/multi_signature_byte_scanner_top.sv
hdl/msbs_checker.sv
tb/tb_multi_signature_byte_scanner_top.sv
